// File: design/mpi_pkg.sv
`default_nettype none
package mpi_pkg;

  localparam int unsigned ACC_W  = 56;
  localparam int unsigned STEP_W = 25;
  localparam int unsigned NCH_W  = 5;
  localparam int unsigned CH_W   = 4;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned POW_W  = 32;
  localparam int unsigned ADDR_W = 2;

  localparam logic [ADDR_W-1:0] CFG_NUM_CHANNELS  = 2'd0;
  localparam logic [ADDR_W-1:0] CFG_COMPLEX_MODE  = 2'd1;
  localparam logic [ADDR_W-1:0] CFG_SAMPLES_PER_INT = 2'd2;

  localparam logic [NCH_W-1:0]  NUM_CHANNELS_RST = 5'd1;
  localparam logic [STEP_W-1:0] SAMPLES_PER_INT_RST = 25'd1000;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } mem_ctrl_t;

endpackage
`default_nettype wire

// File: design/mpi_if.sv
`default_nettype none
interface mpi_sample_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [mpi_pkg::CH_W-1:0]      channel;
  logic signed [SAMPLE_BITS-1:0] real_part;
  logic signed [SAMPLE_BITS-1:0] imag_part;

  modport source (output valid, output channel, output real_part, output imag_part,
                  input ready);
  modport sink (input valid, input channel, input real_part, input imag_part,
                output ready);
endinterface

interface mpi_result_if;
  logic                      valid;
  logic                      ready;
  logic [mpi_pkg::CNT_W-1:0] integration_number;
  logic [mpi_pkg::CH_W-1:0]  out_channel;
  logic [mpi_pkg::POW_W-1:0] mean_power;
  logic                      last;

  modport source (output valid, output integration_number, output out_channel,
                  output mean_power, output last, input ready);
  modport sink (input valid, input integration_number, input out_channel,
                input mean_power, input last, output ready);
endinterface

interface mpi_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mpi_pkg::ADDR_W-1:0] addr;
  logic [mpi_pkg::STEP_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// File: design/mpi_acc_mem.sv
`default_nettype none
module mpi_acc_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mpi_pkg::mem_ctrl_t        ctrl,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [mpi_pkg::ACC_W-1:0] wr_data,
  input  wire logic [AW-1:0]             rd_addr,
  output logic [mpi_pkg::ACC_W-1:0]      rd_data
);

  logic [mpi_pkg::ACC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          valid;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // an entry not written since the last dump reads as zero
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: design/mpi_divider.sv
`default_nettype none
module mpi_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [mpi_pkg::ACC_W-1:0]  dividend,
  input  wire logic [mpi_pkg::STEP_W-1:0] divisor,
  output mpi_pkg::div_status_t            status,
  output logic [mpi_pkg::POW_W-1:0]       quotient
);

  localparam int unsigned CW = $clog2(mpi_pkg::ACC_W + 1);

  logic [mpi_pkg::STEP_W-1:0] rem;
  logic [mpi_pkg::STEP_W-1:0] dsr;
  logic [mpi_pkg::ACC_W-1:0]  dvd;
  logic [mpi_pkg::POW_W-1:0]  quo;
  logic                       sat;
  logic [CW-1:0]              cnt;
  logic [mpi_pkg::STEP_W:0]   trial;
  logic                       fits;
  logic [mpi_pkg::STEP_W:0]   diff;

  always_comb begin
    trial = {rem, dvd[mpi_pkg::ACC_W-1]};
    fits  = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
      quo <= '0;
      sat <= 1'b0;
    end else if (status.busy) begin
      rem <= fits ? diff[mpi_pkg::STEP_W-1:0] : trial[mpi_pkg::STEP_W-1:0];
      dvd <= {dvd[mpi_pkg::ACC_W-2:0], 1'b0};
      // a bit pushed out of the top means the quotient does not fit
      quo <= {quo[mpi_pkg::POW_W-2:0], fits};
      sat <= sat | quo[mpi_pkg::POW_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else if (start) begin
      status.busy <= 1'b1;
      status.done <= 1'b0;
      cnt         <= CW'(mpi_pkg::ACC_W);
    end else if (status.busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        status.busy <= 1'b0;
        status.done <= 1'b1;
      end
    end else begin
      status.done <= 1'b0;
    end
  end

  assign quotient = sat ? '1 : quo;

endmodule
`default_nettype wire

// File: design/multichannel_power_integrator_top.sv
// Channel   | Dir | Carries
// cfg       | in  | addr (register index), data (write value)
// samples   | in  | channel, real_part, imag_part
// results   | out | integration_number, out_channel, mean_power, last
//
// A sample passes S_SQ_RE, in complex mode S_SQ_IM and S_ADD, then S_ACC:
// a single squarer is used once per part, then one saturating add into the
// accumulator. A dump runs each channel through the bit-serial divider and
// waits on any result sink stall; samples are not taken during a dump.
// rst is synchronous and active high; it restores register defaults and
// empties every accumulator at once.
`default_nettype none
module multichannel_power_integrator_top #(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  mpi_cfg_if.sink      cfg,
  mpi_sample_if.sink   samples,
  mpi_result_if.source results
);

  localparam int unsigned AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NW    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned PW    = 2 * SAMPLE_BITS + 1;
  localparam int unsigned SUM_W = ((PW > mpi_pkg::ACC_W) ? PW : mpi_pkg::ACC_W) + 1;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SQ_RE    = 9'b000000010,
    S_SQ_IM    = 9'b000000100,
    S_ADD      = 9'b000001000,
    S_ACC      = 9'b000010000,
    S_DUMP_RD  = 9'b000100000,
    S_DIV_LOAD = 9'b001000000,
    S_DIV_WAIT = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [mpi_pkg::NCH_W-1:0]  num_channels;
  logic                       complex_mode;
  logic [mpi_pkg::STEP_W-1:0] samples_per_integration;

  logic [mpi_pkg::STEP_W-1:0] step_count;
  logic [mpi_pkg::CNT_W-1:0]  integration_counter;

  logic [AW-1:0]              ch;
  logic [SAMPLE_BITS-1:0]     re;
  logic [SAMPLE_BITS-1:0]     im;
  logic [PW-1:0]              power;
  logic [2*SAMPLE_BITS-1:0]   prod;
  logic [AW-1:0]              k;

  logic [NW-1:0]              nc_eff;
  logic [mpi_pkg::STEP_W-1:0] len;
  logic [mpi_pkg::STEP_W-1:0] step_inc;
  logic [AW+mpi_pkg::CH_W-1:0] in_ch_wide;
  logic [AW+mpi_pkg::CH_W-1:0] k_wide;
  logic                       in_accept;
  logic                       in_range;
  logic                       ch_is_last;
  logic                       k_is_last;

  logic [SAMPLE_BITS-1:0]     mul_in;
  logic [SAMPLE_BITS-1:0]     mag;
  logic [2*SAMPLE_BITS-1:0]   mul_out;
  logic [SUM_W-1:0]           acc_sum;
  logic [mpi_pkg::ACC_W-1:0]  acc_new;

  mpi_pkg::mem_ctrl_t         mem_ctrl;
  logic [AW-1:0]              rd_addr;
  logic [mpi_pkg::ACC_W-1:0]  rd_data;

  mpi_pkg::div_status_t       div_status;
  logic [mpi_pkg::POW_W-1:0]  quotient;
  logic                       div_start;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels            <= mpi_pkg::NUM_CHANNELS_RST;
      complex_mode            <= 1'b0;
      samples_per_integration <= mpi_pkg::SAMPLES_PER_INT_RST;
    end else if (cfg.valid) begin
      case (cfg.addr)
        mpi_pkg::CFG_NUM_CHANNELS: begin
          num_channels <= cfg.data[mpi_pkg::NCH_W-1:0];
        end
        mpi_pkg::CFG_COMPLEX_MODE: begin
          complex_mode <= cfg.data[0];
        end
        mpi_pkg::CFG_SAMPLES_PER_INT: begin
          samples_per_integration <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  // clamp channel count and length into their usable ranges
  always_comb begin
    if (num_channels == '0) begin
      nc_eff = NW'(1);
    end else if (32'(num_channels) > 32'(MAX_CHANNELS)) begin
      nc_eff = NW'(MAX_CHANNELS);
    end else begin
      nc_eff = NW'(num_channels);
    end
    len        = (samples_per_integration == '0) ? mpi_pkg::STEP_W'(1)
                                                 : samples_per_integration;
    in_ch_wide = {{AW{1'b0}}, samples.channel};
    k_wide     = {{mpi_pkg::CH_W{1'b0}}, k};
    in_accept  = samples.valid && samples.ready;
    in_range   = 32'(samples.channel) < 32'(nc_eff);
    ch_is_last = 32'(ch) + 32'd1 == 32'(nc_eff);
    k_is_last  = 32'(k) + 32'd1 == 32'(nc_eff);
    step_inc   = step_count + 1'b1;
  end

  // shared squarer
  always_comb begin
    mul_in  = (state == S_SQ_IM) ? im : re;
    mag     = mul_in[SAMPLE_BITS-1] ? (~mul_in + 1'b1) : mul_in;
    mul_out = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
    acc_sum = SUM_W'(rd_data) + SUM_W'(power);
    acc_new = (acc_sum[SUM_W-1:mpi_pkg::ACC_W] != '0) ? mpi_pkg::ACC_MAX
                                                      : acc_sum[mpi_pkg::ACC_W-1:0];
  end

  always_comb begin
    state_next = state;
    mem_ctrl   = '0;
    rd_addr    = k;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        rd_addr        = in_ch_wide[AW-1:0];
        mem_ctrl.rd_en = in_accept;
        if (in_accept && in_range) begin
          state_next = S_SQ_RE;
        end
      end
      S_SQ_RE: begin
        state_next = complex_mode ? S_SQ_IM : S_ACC;
      end
      S_SQ_IM: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        mem_ctrl.wr_en = 1'b1;
        if (ch_is_last && step_inc != '0 && step_inc >= len) begin
          state_next = S_DUMP_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        mem_ctrl.rd_en = 1'b1;
        state_next     = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_status.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (results.ready) begin
          if (k_is_last) begin
            mem_ctrl.clear = 1'b1;
            state_next     = S_IDLE;
          end else begin
            state_next = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign samples.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      step_count          <= '0;
      integration_counter <= '0;
      k                   <= '0;
      results.valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ACC && ch_is_last) begin
        step_count <= step_inc;
        k          <= '0;
      end
      if (state == S_DIV_WAIT && div_status.done) begin
        results.valid <= 1'b1;
      end
      if (state == S_EMIT && results.ready) begin
        results.valid <= 1'b0;
        if (k_is_last) begin
          step_count          <= '0;
          integration_counter <= integration_counter + 1'b1;
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

  // sample and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch <= in_ch_wide[AW-1:0];
      re <= samples.real_part;
      im <= samples.imag_part;
    end
    if (state == S_SQ_RE) begin
      power <= PW'(mul_out);
    end
    if (state == S_SQ_IM) begin
      prod <= mul_out;
    end
    if (state == S_ADD) begin
      power <= power + PW'(prod);
    end
    if (state == S_DIV_WAIT && div_status.done) begin
      results.integration_number <= integration_counter;
      results.out_channel        <= k_wide[mpi_pkg::CH_W-1:0];
      results.mean_power         <= quotient;
      results.last               <= k_is_last;
    end
  end

  mpi_acc_mem #(
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_acc_mem (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mem_ctrl),
    .wr_addr (ch),
    .wr_data (acc_new),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mpi_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (step_count),
    .status   (div_status),
    .quotient (quotient)
  );

endmodule
`default_nettype wire
